FILE: rtl/hps_pkg.sv
// ----------------------------------------------------------------------------
// hps_pkg: shared types and constants of the host power supervisor
// Widths, event kinds, fault codes and register indexes used by the top level
// and by the wake-time unit.
// ----------------------------------------------------------------------------
package hps_pkg;

	localparam int TIME_BITS      = 32;
	localparam int COUNT_BITS     = 16;
	localparam int LIMIT_BITS     = 16;
	localparam int MINUTE_BITS    = 8;
	localparam int LEVEL_BITS     = 10;
	localparam int KIND_BITS      = 3;
	localparam int FAULT_BITS     = 2;
	localparam int STATUS_BITS    = 3;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 32;
	localparam int FIELD_TIME_BITS = 32;
	localparam int ANCHOR_BITS    = 32;

	localparam int SECS_PER_MIN   = 60;
	localparam int STEP_MAX       = (2 ** MINUTE_BITS - 1) * SECS_PER_MIN;
	localparam int STEP_BITS      = $clog2(STEP_MAX + 1);
	localparam int DIV_CNT_BITS   = $clog2(TIME_BITS);
	localparam int CMP_BITS       = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

	// Event kinds
	localparam logic [KIND_BITS-1:0] KIND_TICK      = 3'd0;
	localparam logic [KIND_BITS-1:0] KIND_POLL      = 3'd1;
	localparam logic [KIND_BITS-1:0] KIND_HEARTBEAT = 3'd2;
	localparam logic [KIND_BITS-1:0] KIND_HALT      = 3'd3;
	localparam logic [KIND_BITS-1:0] KIND_REINIT    = 3'd4;

	// Fault codes
	localparam logic [FAULT_BITS-1:0] FAULT_NONE      = 2'd0;
	localparam logic [FAULT_BITS-1:0] FAULT_UNPOWERED = 2'd1;
	localparam logic [FAULT_BITS-1:0] FAULT_BOOT      = 2'd2;
	localparam logic [FAULT_BITS-1:0] FAULT_VOLTAGE   = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_BOOT_LIMIT    = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_HALT_LIMIT    = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WAKE_STEP     = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WAKE_ANCHOR   = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_VOLTAGE_FLOOR = 3'd4;

	// Handshake between the sequencer and the wake-time unit
	typedef struct packed {
		logic                 done;
		logic [TIME_BITS-1:0] wake;
	} wake_rsp_t;

endpackage

FILE: rtl/hps_wake_unit.sv
// ----------------------------------------------------------------------------
// hps_wake_unit: iterative wake-time calculator
// Computes the next step-aligned restart time after the anchor with a
// bit-serial restoring remainder, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hps_wake_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [hps_pkg::TIME_BITS-1:0]      now,
	input  logic [hps_pkg::TIME_BITS-1:0]      anchor,
	input  logic [hps_pkg::MINUTE_BITS-1:0]    minutes,
	output hps_pkg::wake_rsp_t                 rsp
);

	typedef enum logic [3:0] {
		W_IDLE = 4'b0001,
		W_PREP = 4'b0010,
		W_DIV  = 4'b0100,
		W_FIN  = 4'b1000
	} wstate_t;

	wstate_t                              state_q;
	logic [hps_pkg::STEP_BITS-1:0]        step_q;
	logic [hps_pkg::STEP_BITS-1:0]        rem_q;
	logic [hps_pkg::TIME_BITS-1:0]        diff_q;
	logic                                 late_q;
	logic [hps_pkg::DIV_CNT_BITS-1:0]     cnt_q;
	logic [hps_pkg::TIME_BITS-1:0]        wake_q;
	logic                                 done_q;

	logic [hps_pkg::STEP_BITS-1:0]        prod;
	logic [hps_pkg::STEP_BITS:0]          trial;
	logic [hps_pkg::STEP_BITS:0]          step_ext;
	logic [hps_pkg::STEP_BITS-1:0]        gap;

	assign prod     = hps_pkg::STEP_BITS'(minutes) *
		hps_pkg::STEP_BITS'(hps_pkg::SECS_PER_MIN);
	assign trial    = {rem_q, diff_q[hps_pkg::TIME_BITS-1]};
	assign step_ext = {1'b0, step_q};
	assign gap      = step_q - rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				W_IDLE: begin
					if (start) begin
						state_q <= W_PREP;
					end
				end
				W_PREP: state_q <= W_DIV;
				W_DIV: begin
					if (cnt_q == hps_pkg::DIV_CNT_BITS'(hps_pkg::TIME_BITS - 1)) begin
						state_q <= W_FIN;
					end
				end
				W_FIN: begin
					done_q  <= 1'b1;
					state_q <= W_IDLE;
				end
				default: state_q <= W_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			W_PREP: begin
				step_q <= (minutes == '0) ?
					hps_pkg::STEP_BITS'(hps_pkg::SECS_PER_MIN) : prod;
				diff_q <= now - anchor;
				late_q <= now > anchor;
				rem_q  <= '0;
				cnt_q  <= '0;
			end
			W_DIV: begin
				// shift in one dividend bit, subtract the step when it fits
				if (trial >= step_ext) begin
					rem_q <= hps_pkg::STEP_BITS'(trial - step_ext);
				end else begin
					rem_q <= trial[hps_pkg::STEP_BITS-1:0];
				end
				diff_q <= diff_q << 1;
				cnt_q  <= cnt_q + 1'b1;
			end
			W_FIN: begin
				wake_q <= late_q ? (now + hps_pkg::TIME_BITS'(gap)) : anchor;
			end
			default: begin
			end
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.wake = wake_q;

endmodule

FILE: rtl/host_power_supervisor_top.sv
// ----------------------------------------------------------------------------
// host_power_supervisor_top: host power relay supervisor
// Takes one event per transaction and returns one result transaction that
// reports relay pulses, fault code, status and the scheduled wake time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one event: kind, now,
//   power_good, supply_level, halt_enable. Output channel (out_valid /
//   out_stall) returns exactly one result transaction per event.
//   Configuration writes go through cfg_valid / cfg_ready with cfg_index
//   selecting boot_limit, halt_limit, wake_step_minutes, wake_anchor or
//   voltage_floor; indexes beyond the list are taken and ignored.
//   Sequence: an event that needs no wake time goes from accept through the
//   evaluate state to the output handover. One that recomputes the wake time
//   also waits for the bit-serial remainder unit, which retires one dividend
//   bit per cycle. One event is in work at a time; the next is taken once
//   the result has moved into the output register.
//   Reset: registers return to their default limits, the host is considered
//   stopped and on first run, and no result is pending.
//   Stall: a stalled result holds in the output register; the next event
//   may still be taken and waits for the register to free before delivery.
// ----------------------------------------------------------------------------
module host_power_supervisor_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// event channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [hps_pkg::KIND_BITS-1:0]         kind,
	input  logic [hps_pkg::FIELD_TIME_BITS-1:0]   now,
	input  logic                                  power_good,
	input  logic [hps_pkg::LEVEL_BITS-1:0]        supply_level,
	input  logic                                  halt_enable,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  relay_on_pulse,
	output logic                                  relay_off_pulse,
	output logic [hps_pkg::FAULT_BITS-1:0]        fault,
	output logic [hps_pkg::STATUS_BITS-1:0]       status,
	output logic [hps_pkg::FIELD_TIME_BITS-1:0]   wake_time,
	// configuration channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [hps_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [hps_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EVAL = 4'b0010,
		S_WAIT = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [hps_pkg::LIMIT_BITS-1:0]   boot_limit_q;
	logic [hps_pkg::LIMIT_BITS-1:0]   halt_limit_q;
	logic [hps_pkg::MINUTE_BITS-1:0]  wake_step_q;
	logic [hps_pkg::ANCHOR_BITS-1:0]  wake_anchor_q;
	logic [hps_pkg::LEVEL_BITS-1:0]   voltage_floor_q;

	// supervisor state
	logic                             first_run_q;
	logic                             started_q;
	logic                             halting_q;
	logic                             booted_q;
	logic [hps_pkg::COUNT_BITS-1:0]   boot_count_q;
	logic [hps_pkg::COUNT_BITS-1:0]   halt_count_q;
	logic [hps_pkg::TIME_BITS-1:0]    restart_at_q;

	// captured event
	logic [hps_pkg::KIND_BITS-1:0]    kind_q;
	logic [hps_pkg::TIME_BITS-1:0]    now_q;
	logic                             pgood_q;
	logic [hps_pkg::LEVEL_BITS-1:0]   supply_q;
	logic                             hen_q;

	// per-event result bits, held until delivery
	logic                             on_q;
	logic                             off_q;
	logic [hps_pkg::FAULT_BITS-1:0]   fault_q;

	// output register
	logic                                  out_valid_q;
	logic                                  out_on_q;
	logic                                  out_off_q;
	logic [hps_pkg::FAULT_BITS-1:0]        out_fault_q;
	logic [hps_pkg::STATUS_BITS-1:0]       out_status_q;
	logic [hps_pkg::FIELD_TIME_BITS-1:0]   out_wake_q;

	// next-state values from the event decoder
	logic                             first_run_d;
	logic                             started_d;
	logic                             halting_d;
	logic                             booted_d;
	logic [hps_pkg::COUNT_BITS-1:0]   boot_count_d;
	logic [hps_pkg::COUNT_BITS-1:0]   halt_count_d;
	logic                             on_d;
	logic                             off_d;
	logic [hps_pkg::FAULT_BITS-1:0]   fault_d;
	logic                             need_wake;

	logic [hps_pkg::CMP_BITS-1:0]     boot_cnt_x;
	logic [hps_pkg::CMP_BITS-1:0]     halt_cnt_x;
	logic [hps_pkg::CMP_BITS-1:0]     boot_lim_x;
	logic [hps_pkg::CMP_BITS-1:0]     halt_lim_x;
	logic                             due;

	logic                             in_take;
	logic                             out_load;
	logic                             wake_start;
	hps_pkg::wake_rsp_t               wake_rsp;

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || !out_stall);
	assign wake_start = (state_q == S_EVAL) && need_wake;

	assign boot_cnt_x = hps_pkg::CMP_BITS'(boot_count_q);
	assign halt_cnt_x = hps_pkg::CMP_BITS'(halt_count_q);
	assign boot_lim_x = hps_pkg::CMP_BITS'(boot_limit_q);
	assign halt_lim_x = hps_pkg::CMP_BITS'(halt_limit_q);
	assign due        = now_q >= restart_at_q;

	// Decode the captured event against the current state.
	always_comb begin
		first_run_d  = first_run_q;
		started_d    = started_q;
		halting_d    = halting_q;
		booted_d     = booted_q;
		boot_count_d = boot_count_q;
		halt_count_d = halt_count_q;
		on_d         = 1'b0;
		off_d        = 1'b0;
		fault_d      = hps_pkg::FAULT_NONE;
		need_wake    = 1'b0;
		case (kind_q)
			hps_pkg::KIND_TICK: begin
				// advance the halt cooldown first, else the boot cooldown
				if (started_q) begin
					if (halting_q && (halt_cnt_x < halt_lim_x)) begin
						if (halt_count_q != '1) begin
							halt_count_d = halt_count_q + 1'b1;
						end
					end else if (!booted_q && (boot_cnt_x < boot_lim_x)) begin
						if (boot_count_q != '1) begin
							boot_count_d = boot_count_q + 1'b1;
						end
					end
				end
			end
			hps_pkg::KIND_POLL: begin
				if (!started_q) begin
					if (first_run_q || due) begin
						if (supply_q <= voltage_floor_q) begin
							// refuse the start, leave state alone
							fault_d = hps_pkg::FAULT_VOLTAGE;
						end else begin
							on_d         = 1'b1;
							started_d    = 1'b1;
							halting_d    = 1'b0;
							booted_d     = 1'b0;
							boot_count_d = '0;
							halt_count_d = '0;
							need_wake    = 1'b1;
						end
					end
				end else begin
					need_wake = due;
					if (halting_q) begin
						if (halt_cnt_x >= halt_lim_x) begin
							off_d        = 1'b1;
							first_run_d  = 1'b0;
							started_d    = 1'b0;
							halting_d    = 1'b0;
							booted_d     = 1'b0;
							boot_count_d = '0;
							halt_count_d = '0;
						end
					end else if (!pgood_q && (boot_count_q != '0)) begin
						fault_d = hps_pkg::FAULT_UNPOWERED;
					end else if (!booted_q && (boot_cnt_x >= boot_lim_x)) begin
						fault_d = hps_pkg::FAULT_BOOT;
					end
				end
			end
			hps_pkg::KIND_HEARTBEAT: begin
				boot_count_d = '0;
				halt_count_d = '0;
				booted_d     = 1'b1;
			end
			hps_pkg::KIND_HALT: begin
				boot_count_d = '0;
				halt_count_d = '0;
				halting_d    = hen_q;
			end
			hps_pkg::KIND_REINIT: begin
				first_run_d  = 1'b1;
				started_d    = pgood_q;
				halting_d    = 1'b0;
				booted_d     = 1'b0;
				boot_count_d = '0;
				halt_count_d = '0;
				need_wake    = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sequencer and supervisor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			boot_limit_q    <= hps_pkg::LIMIT_BITS'(120);
			halt_limit_q    <= hps_pkg::LIMIT_BITS'(30);
			wake_step_q     <= '0;
			wake_anchor_q   <= '0;
			voltage_floor_q <= '0;
			first_run_q     <= 1'b1;
			started_q       <= 1'b0;
			halting_q       <= 1'b0;
			booted_q        <= 1'b0;
			boot_count_q    <= '0;
			halt_count_q    <= '0;
			restart_at_q    <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			// register writes; unknown indexes drop
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					hps_pkg::REG_BOOT_LIMIT:
						boot_limit_q <= cfg_data[hps_pkg::LIMIT_BITS-1:0];
					hps_pkg::REG_HALT_LIMIT:
						halt_limit_q <= cfg_data[hps_pkg::LIMIT_BITS-1:0];
					hps_pkg::REG_WAKE_STEP:
						wake_step_q <= cfg_data[hps_pkg::MINUTE_BITS-1:0];
					hps_pkg::REG_WAKE_ANCHOR:
						wake_anchor_q <= cfg_data[hps_pkg::ANCHOR_BITS-1:0];
					hps_pkg::REG_VOLTAGE_FLOOR:
						voltage_floor_q <= cfg_data[hps_pkg::LEVEL_BITS-1:0];
					default: begin
					end
				endcase
			end

			// load a new result, else retire a delivered one
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					first_run_q  <= first_run_d;
					started_q    <= started_d;
					halting_q    <= halting_d;
					booted_q     <= booted_d;
					boot_count_q <= boot_count_d;
					halt_count_q <= halt_count_d;
					state_q      <= need_wake ? S_WAIT : S_OUT;
				end
				S_WAIT: begin
					if (wake_rsp.done) begin
						restart_at_q <= wake_rsp.wake;
						state_q      <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Event capture, result bits and output payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_q   <= kind;
			now_q    <= hps_pkg::TIME_BITS'(now);
			pgood_q  <= power_good;
			supply_q <= supply_level;
			hen_q    <= halt_enable;
		end
		if (state_q == S_EVAL) begin
			on_q    <= on_d;
			off_q   <= off_d;
			fault_q <= fault_d;
		end
		if (out_load) begin
			out_on_q     <= on_q;
			out_off_q    <= off_q;
			out_fault_q  <= fault_q;
			out_status_q <= {halting_q, booted_q, pgood_q};
			out_wake_q   <= hps_pkg::FIELD_TIME_BITS'(restart_at_q);
		end
	end

	hps_wake_unit u_wake (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (wake_start),
		.now     (now_q),
		.anchor  (hps_pkg::TIME_BITS'(wake_anchor_q)),
		.minutes (wake_step_q),
		.rsp     (wake_rsp)
	);

	assign out_valid       = out_valid_q;
	assign relay_on_pulse  = out_on_q;
	assign relay_off_pulse = out_off_q;
	assign fault           = out_fault_q;
	assign status          = out_status_q;
	assign wake_time       = out_wake_q;

	// The wake unit answers only while the sequencer waits for it.
	a_wake_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		wake_rsp.done |-> (state_q == S_WAIT))
		else $error("wake unit finished outside the wait state");

	// A new result appears only when the sequencer hands one over.
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result valid rose without a handover");

	// Both relay pulses never leave with one result.
	a_pulse_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_on_q && out_off_q))
		else $error("relay on and off pulses together");

	// A switch-on leaves the host started, a switch-off leaves it stopped.
	a_on_started: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && on_q) |-> started_q)
		else $error("switch-on without started host");

	a_off_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && off_q) |-> (!started_q && !first_run_q))
		else $error("switch-off left host marked started");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the host power supervisor
// Drives supervisor events through the stall handshake and tracks the relay,
// fault, status and wake-time behavior in a local model. Every result
// transaction is compared field by field with the model's prediction. A
// directed sequence is followed by randomized traffic under several register
// settings and idle patterns.
// ----------------------------------------------------------------------------
module tb;

	localparam int SETTLE_CYCLES = 48;      // longer than the slowest event latency
	localparam int CYCLE_LIMIT   = 800000;  // generous bound on the whole run
	localparam int PRINT_CAP     = 40;
	localparam int RAND_BLOCK    = 70;      // events between register changes

	typedef struct packed {
		logic [hps_pkg::KIND_BITS-1:0]       kind;
		logic [hps_pkg::FIELD_TIME_BITS-1:0] now;
		logic                                pgood;
		logic [hps_pkg::LEVEL_BITS-1:0]      supply;
		logic                                hen;
	} supv_event_t;

	typedef struct packed {
		logic                            relay_on;
		logic                            relay_off;
		logic [hps_pkg::FAULT_BITS-1:0]  fault_code;
		logic [hps_pkg::STATUS_BITS-1:0] status_bits;
		logic [hps_pkg::TIME_BITS-1:0]   wake_at;
	} outcome_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [hps_pkg::KIND_BITS-1:0] kind;
	logic [hps_pkg::FIELD_TIME_BITS-1:0] now;
	logic power_good;
	logic [hps_pkg::LEVEL_BITS-1:0] supply_level;
	logic halt_enable;
	logic out_valid;
	logic out_stall = 1'b0;
	logic relay_on_pulse;
	logic relay_off_pulse;
	logic [hps_pkg::FAULT_BITS-1:0] fault;
	logic [hps_pkg::STATUS_BITS-1:0] status;
	logic [hps_pkg::FIELD_TIME_BITS-1:0] wake_time;
	logic cfg_valid;
	logic cfg_ready;
	logic [hps_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [hps_pkg::CFG_DATA_BITS-1:0] cfg_data;

	host_power_supervisor_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.now(now),
		.power_good(power_good),
		.supply_level(supply_level),
		.halt_enable(halt_enable),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.relay_on_pulse(relay_on_pulse),
		.relay_off_pulse(relay_off_pulse),
		.fault(fault),
		.status(status),
		.wake_time(wake_time),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Supervisor model: registers
	logic [hps_pkg::LIMIT_BITS-1:0]  lim_boot;
	logic [hps_pkg::LIMIT_BITS-1:0]  lim_halt;
	logic [hps_pkg::MINUTE_BITS-1:0] wake_minutes;
	logic [hps_pkg::ANCHOR_BITS-1:0] wake_base;
	logic [hps_pkg::LEVEL_BITS-1:0]  volt_floor;

	// Supervisor model: state
	logic sup_first_run;
	logic sup_started;
	logic sup_halting;
	logic sup_booted;
	logic [hps_pkg::COUNT_BITS-1:0] boot_ticks;
	logic [hps_pkg::COUNT_BITS-1:0] halt_ticks;
	logic [hps_pkg::TIME_BITS-1:0]  restart_time;

	outcome_t pending_results[$];
	int error_count = 0;
	int cycle_count = 0;
	int send_idle_pct;
	int stall_pct;
	logic [hps_pkg::TIME_BITS-1:0] time_cursor;

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Hold the run to a bounded number of cycles
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Receiver: stall at random with the current percentage, change at the falling edge
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic flag_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (error_count < PRINT_CAP)
			$display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		error_count++;
	endtask

	// Compare every accepted result transaction with the oldest prediction
	always @(posedge clk) begin : check_results
		outcome_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("unexpected result", 32'(wake_time), '0);
			end else begin
				want = pending_results.pop_front();
				if (relay_on_pulse !== want.relay_on)
					flag_mismatch("relay_on_pulse", 32'(relay_on_pulse),
						32'(want.relay_on));
				if (relay_off_pulse !== want.relay_off)
					flag_mismatch("relay_off_pulse", 32'(relay_off_pulse),
						32'(want.relay_off));
				if (fault !== want.fault_code)
					flag_mismatch("fault", 32'(fault), 32'(want.fault_code));
				if (status !== want.status_bits)
					flag_mismatch("status", 32'(status), 32'(want.status_bits));
				if (wake_time !== want.wake_at)
					flag_mismatch("wake_time", 32'(wake_time), 32'(want.wake_at));
			end
		end
	end

	// Next restart time aligned to the anchor, wrapped to the time width
	function automatic logic [hps_pkg::TIME_BITS-1:0] next_wake(
		input logic [hps_pkg::TIME_BITS-1:0] t);
		logic [63:0] step;
		logic [63:0] t64;
		logic [63:0] a64;
		step = 64'(wake_minutes) * 64'(hps_pkg::SECS_PER_MIN);
		if (step == 0)
			step = 64'(hps_pkg::SECS_PER_MIN);
		t64 = 64'(t);
		a64 = 64'(wake_base);
		if (t64 > a64)
			return hps_pkg::TIME_BITS'(t64 + step - ((t64 - a64) % step));
		return hps_pkg::TIME_BITS'(wake_base);
	endfunction

	// Advance the supervisor model by one event and return its result
	function automatic outcome_t supervise(input supv_event_t ev);
		outcome_t r;
		r = '0;
		case (ev.kind)
			hps_pkg::KIND_TICK: begin
				if (sup_started) begin
					if (sup_halting && halt_ticks < lim_halt)
						halt_ticks++;
					else if (!sup_booted && boot_ticks < lim_boot)
						boot_ticks++;
				end
			end
			hps_pkg::KIND_POLL: begin
				if (!sup_started) begin
					if (sup_first_run || ev.now >= restart_time) begin
						if (ev.supply <= volt_floor) begin
							r.fault_code = hps_pkg::FAULT_VOLTAGE;
						end else begin
							r.relay_on = 1'b1;
							sup_started = 1'b1;
							sup_halting = 1'b0;
							sup_booted = 1'b0;
							boot_ticks = '0;
							halt_ticks = '0;
							restart_time = next_wake(ev.now);
						end
					end
				end else begin
					if (ev.now >= restart_time)
						restart_time = next_wake(ev.now);
					if (sup_halting) begin
						if (halt_ticks >= lim_halt) begin
							r.relay_off = 1'b1;
							sup_first_run = 1'b0;
							sup_started = 1'b0;
							sup_halting = 1'b0;
							sup_booted = 1'b0;
							boot_ticks = '0;
							halt_ticks = '0;
						end
					end else if (!ev.pgood && boot_ticks > 0) begin
						r.fault_code = hps_pkg::FAULT_UNPOWERED;
					end else if (!sup_booted && boot_ticks >= lim_boot) begin
						r.fault_code = hps_pkg::FAULT_BOOT;
					end
				end
			end
			hps_pkg::KIND_HEARTBEAT: begin
				boot_ticks = '0;
				halt_ticks = '0;
				sup_booted = 1'b1;
			end
			hps_pkg::KIND_HALT: begin
				boot_ticks = '0;
				halt_ticks = '0;
				sup_halting = ev.hen;
			end
			hps_pkg::KIND_REINIT: begin
				sup_first_run = 1'b1;
				sup_started = ev.pgood;
				sup_halting = 1'b0;
				sup_booted = 1'b0;
				boot_ticks = '0;
				halt_ticks = '0;
				restart_time = next_wake(ev.now);
			end
			default: ;
		endcase
		r.status_bits = {sup_halting, sup_booted, ev.pgood};
		r.wake_at = restart_time;
		return r;
	endfunction

	// Send one event; predict its result once the transaction is taken
	task automatic send_event(input supv_event_t ev);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		kind <= ev.kind;
		now <= ev.now;
		power_good <= ev.pgood;
		supply_level <= ev.supply;
		halt_enable <= ev.hen;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(supervise(ev));
	endtask

	// Drop valid, wait until every predicted result is back, then let the block settle
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write; only called while the block is idle
	task automatic write_reg(input logic [hps_pkg::CFG_INDEX_BITS-1:0] idx,
		input logic [hps_pkg::CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			hps_pkg::REG_BOOT_LIMIT:    lim_boot = data[hps_pkg::LIMIT_BITS-1:0];
			hps_pkg::REG_HALT_LIMIT:    lim_halt = data[hps_pkg::LIMIT_BITS-1:0];
			hps_pkg::REG_WAKE_STEP:     wake_minutes = data[hps_pkg::MINUTE_BITS-1:0];
			hps_pkg::REG_WAKE_ANCHOR:   wake_base = data[hps_pkg::ANCHOR_BITS-1:0];
			hps_pkg::REG_VOLTAGE_FLOOR: volt_floor = data[hps_pkg::LEVEL_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random event: mostly plausible traffic around the scheduled wake time
	function automatic supv_event_t random_event();
		supv_event_t ev;
		int pick;
		pick = $urandom_range(99);
		if (pick < 38)
			ev.kind = hps_pkg::KIND_TICK;
		else if (pick < 70)
			ev.kind = hps_pkg::KIND_POLL;
		else if (pick < 79)
			ev.kind = hps_pkg::KIND_HEARTBEAT;
		else if (pick < 92)
			ev.kind = hps_pkg::KIND_HALT;
		else if (pick < 97)
			ev.kind = hps_pkg::KIND_REINIT;
		else
			ev.kind = hps_pkg::KIND_BITS'($urandom_range(int'(hps_pkg::KIND_REINIT) + 1,
				2 ** hps_pkg::KIND_BITS - 1));
		pick = $urandom_range(99);
		if (pick < 55) begin
			time_cursor = time_cursor + hps_pkg::TIME_BITS'($urandom_range(0, 40));
			ev.now = time_cursor;
		end else if (pick < 80) begin
			// land just before, on or after the restart time
			ev.now = restart_time + hps_pkg::TIME_BITS'($urandom_range(0, 2)) - 1'b1;
			time_cursor = ev.now;
		end else if (pick < 90) begin
			ev.now = wake_base + hps_pkg::TIME_BITS'($urandom_range(0, 2)) - 1'b1;
		end else begin
			ev.now = $urandom();
		end
		pick = $urandom_range(99);
		if (pick < 10)
			ev.supply = volt_floor;
		else if (pick < 25 || volt_floor == '1)
			ev.supply = hps_pkg::LEVEL_BITS'($urandom_range(0, 2 ** hps_pkg::LEVEL_BITS - 1));
		else
			ev.supply = hps_pkg::LEVEL_BITS'($urandom_range(int'(volt_floor) + 1,
				2 ** hps_pkg::LEVEL_BITS - 1));
		ev.pgood = ($urandom_range(99) < 85);
		ev.hen = ($urandom_range(99) < 70);
		return ev;
	endfunction

	// Pick a register setting; small limits most of the time so counters saturate
	task automatic random_settings();
		int pick;
		logic [hps_pkg::LIMIT_BITS-1:0] boot_v;
		logic [hps_pkg::LIMIT_BITS-1:0] halt_v;
		logic [hps_pkg::MINUTE_BITS-1:0] step_v;
		logic [hps_pkg::ANCHOR_BITS-1:0] anchor_v;
		logic [hps_pkg::LEVEL_BITS-1:0] floor_v;
		pick = $urandom_range(99);
		boot_v = (pick < 12) ? '0 : (pick < 20) ? '1 :
			hps_pkg::LIMIT_BITS'($urandom_range(1, 12));
		pick = $urandom_range(99);
		halt_v = (pick < 12) ? '0 : (pick < 20) ? '1 :
			hps_pkg::LIMIT_BITS'($urandom_range(1, 10));
		pick = $urandom_range(99);
		step_v = (pick < 20) ? '0 : (pick < 35) ? '1 :
			hps_pkg::MINUTE_BITS'($urandom_range(1, 255));
		pick = $urandom_range(99);
		if (pick < 20)
			anchor_v = '0;
		else if (pick < 28)
			anchor_v = '1;
		else if (pick < 70)
			anchor_v = time_cursor + hps_pkg::ANCHOR_BITS'($urandom_range(0, 3000));
		else
			anchor_v = $urandom();
		pick = $urandom_range(99);
		floor_v = (pick < 15) ? '0 : (pick < 19) ? '1 :
			hps_pkg::LEVEL_BITS'($urandom_range(0, 700));
		// random upper data bits are ignored by the narrow registers
		write_reg(hps_pkg::REG_BOOT_LIMIT, {16'($urandom()), boot_v});
		write_reg(hps_pkg::REG_HALT_LIMIT, {16'($urandom()), halt_v});
		write_reg(hps_pkg::REG_WAKE_STEP, {24'($urandom()), step_v});
		write_reg(hps_pkg::REG_WAKE_ANCHOR, anchor_v);
		write_reg(hps_pkg::REG_VOLTAGE_FLOOR, {22'($urandom()), floor_v});
	endtask

	// Defaults after reset: first poll refused at floor zero, then started
	task automatic test_reset_defaults();
		send_event('{hps_pkg::KIND_POLL, 32'd0, 1'b1, 10'd0, 1'b0});
		send_event('{hps_pkg::KIND_POLL, 32'd0, 1'b1, 10'd5, 1'b0});
		drain_results();
	endtask

	// Walk through power-on, faults, heartbeat, halt and wake-time wrap
	task automatic test_event_sequence();
		int k;
		write_reg(hps_pkg::REG_BOOT_LIMIT, 32'd2);
		write_reg(hps_pkg::REG_HALT_LIMIT, 32'd1);
		write_reg(hps_pkg::REG_WAKE_STEP, 32'd0);
		write_reg(hps_pkg::REG_WAKE_ANCHOR, 32'd0);
		write_reg(hps_pkg::REG_VOLTAGE_FLOOR, 32'd100);
		send_event('{hps_pkg::KIND_REINIT, 32'd0, 1'b0, 10'd0, 1'b0});
		// supply exactly at the floor refuses the start
		send_event('{hps_pkg::KIND_POLL, 32'd0, 1'b1, 10'd100, 1'b0});
		send_event('{hps_pkg::KIND_POLL, 32'd0, 1'b1, 10'd1023, 1'b0});
		// power lost but no tick yet: no fault
		send_event('{hps_pkg::KIND_POLL, 32'd1, 1'b0, 10'd1023, 1'b0});
		send_event('{hps_pkg::KIND_TICK, 32'd2, 1'b1, 10'd0, 1'b0});
		send_event('{hps_pkg::KIND_POLL, 32'd3, 1'b0, 10'd0, 1'b0});
		send_event('{hps_pkg::KIND_TICK, 32'd4, 1'b1, 10'd0, 1'b0});
		send_event('{hps_pkg::KIND_TICK, 32'd5, 1'b1, 10'd0, 1'b0});
		send_event('{hps_pkg::KIND_POLL, 32'd6, 1'b1, 10'd0, 1'b0});
		send_event('{hps_pkg::KIND_HEARTBEAT, 32'd7, 1'b1, 10'd0, 1'b0});
		send_event('{hps_pkg::KIND_POLL, 32'd8, 1'b1, 10'd0, 1'b0});
		send_event('{hps_pkg::KIND_HALT, 32'd9, 1'b1, 10'd0, 1'b1});
		send_event('{hps_pkg::KIND_POLL, 32'd10, 1'b1, 10'd0, 1'b0});
		send_event('{hps_pkg::KIND_TICK, 32'd11, 1'b1, 10'd0, 1'b0});
		send_event('{hps_pkg::KIND_TICK, 32'd12, 1'b1, 10'd0, 1'b0});
		// halt done at the top of the time range: wake time wraps
		send_event('{hps_pkg::KIND_POLL, 32'hFFFF_FFFF, 1'b1, 10'd0, 1'b0});
		send_event('{hps_pkg::KIND_POLL, 32'd0, 1'b1, 10'd1023, 1'b0});
		send_event('{hps_pkg::KIND_POLL, 32'd44, 1'b1, 10'd101, 1'b0});
		send_event('{hps_pkg::KIND_HALT, 32'd45, 1'b0, 10'd0, 1'b0});
		send_event('{hps_pkg::KIND_REINIT, 32'd5, 1'b1, 10'd0, 1'b0});
		send_event('{hps_pkg::KIND_REINIT, 32'd6, 1'b0, 10'd0, 1'b0});
		// unused kinds leave the state alone
		for (k = int'(hps_pkg::KIND_REINIT) + 1; k < 2 ** hps_pkg::KIND_BITS; k++)
			send_event('{hps_pkg::KIND_BITS'(k), 32'hA5A5_5A5A, 1'b1, 10'h2AA, 1'b1});
		drain_results();
	endtask

	// Register extremes, including indexes past the register list
	task automatic test_register_extremes();
		int k;
		write_reg(hps_pkg::REG_BOOT_LIMIT, 32'd0);
		write_reg(hps_pkg::REG_HALT_LIMIT, 32'd0);
		write_reg(hps_pkg::REG_WAKE_STEP, 32'd255);
		write_reg(hps_pkg::REG_WAKE_ANCHOR, 32'hFFFF_FFFF);
		write_reg(hps_pkg::REG_VOLTAGE_FLOOR, 32'd1023);
		for (k = int'(hps_pkg::REG_VOLTAGE_FLOOR) + 1; k < 2 ** hps_pkg::CFG_INDEX_BITS;
			k++)
			write_reg(hps_pkg::CFG_INDEX_BITS'(k), $urandom());
		send_event('{hps_pkg::KIND_REINIT, 32'hFFFF_FFFF, 1'b1, 10'd0, 1'b0});
		send_event('{hps_pkg::KIND_POLL, 32'd100, 1'b1, 10'd1023, 1'b0});
		send_event('{hps_pkg::KIND_HALT, 32'd101, 1'b1, 10'd0, 1'b1});
		send_event('{hps_pkg::KIND_POLL, 32'd102, 1'b1, 10'd0, 1'b0});
		send_event('{hps_pkg::KIND_POLL, 32'hFFFF_FFFF, 1'b1, 10'd1023, 1'b0});
		drain_results();
		write_reg(hps_pkg::REG_BOOT_LIMIT, 32'hFFFF);
		write_reg(hps_pkg::REG_HALT_LIMIT, 32'hFFFF);
		write_reg(hps_pkg::REG_WAKE_STEP, 32'd0);
		write_reg(hps_pkg::REG_WAKE_ANCHOR, 32'd0);
		write_reg(hps_pkg::REG_VOLTAGE_FLOOR, 32'd0);
		send_event('{hps_pkg::KIND_POLL, 32'hFFFF_FFFF, 1'b1, 10'd1, 1'b0});
		send_event('{hps_pkg::KIND_TICK, 32'd0, 1'b1, 10'd0, 1'b0});
		send_event('{hps_pkg::KIND_POLL, 32'h8000_0000, 1'b1, 10'd0, 1'b0});
		drain_results();
	endtask

	// Random traffic in blocks, with a fresh register setting before each block
	task automatic test_random_traffic(input int idle_pct, input int stall_in_pct,
		input int count);
		int sent;
		send_idle_pct = idle_pct;
		stall_pct = stall_in_pct;
		sent = 0;
		while (sent < count) begin
			if (sent % RAND_BLOCK == 0) begin
				drain_results();
				random_settings();
			end else if ($urandom_range(99) == 0) begin
				// hold off until the block has returned everything
				drain_results();
			end
			send_event(random_event());
			sent++;
		end
		drain_results();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = '0;
		now = '0;
		power_good = 1'b0;
		supply_level = '0;
		halt_enable = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		time_cursor = '0;
		lim_boot = 16'd120;
		lim_halt = 16'd30;
		wake_minutes = '0;
		wake_base = '0;
		volt_floor = '0;
		sup_first_run = 1'b1;
		sup_started = 1'b0;
		sup_halting = 1'b0;
		sup_booted = 1'b0;
		boot_ticks = '0;
		halt_ticks = '0;
		restart_time = '0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		send_idle_pct = 30;
		stall_pct = 30;
		test_event_sequence();
		test_register_extremes();
		test_random_traffic(0, 0, 350);
		test_random_traffic(45, 0, 350);
		test_random_traffic(0, 45, 350);
		test_random_traffic(32, 32, 350);

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: files.f
rtl/hps_pkg.sv
rtl/hps_wake_unit.sv
rtl/host_power_supervisor_top.sv
bench/tb.sv
